@@ rtl/spa_pkg.sv @@
package spa_pkg;

    localparam int MAX_SLOTS  = 64;
    localparam int GEN_BITS   = 16;
    localparam int IDX_W      = $clog2(MAX_SLOTS);
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int BYTES_W    = 13;
    localparam int OFF_W      = 18;
    localparam int DIV_W      = $clog2(OFF_W);
    localparam int SEQ_W      = (IDX_W > DIV_W) ? IDX_W : DIV_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [BYTES_W-1:0] SLOT_BYTES_RST   = BYTES_W'(64);
    localparam logic [CNT_W-1:0]   SLOTS_IN_USE_RST = CNT_W'(64);

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        OP_GET  = 2'd0,
        OP_RET  = 2'd1,
        OP_INIT = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

endpackage

@@ rtl/spa_if.sv @@
interface spa_in_if;
    logic                      valid;
    logic                      ready;
    spa_pkg::t_op              opcode;
    logic [spa_pkg::OFF_W-1:0] byte_offset;

    modport source (output valid, opcode, byte_offset, input ready);
    modport sink   (input valid, opcode, byte_offset, output ready);
endinterface

interface spa_out_if;
    logic                         valid;
    logic                         ready;
    logic [spa_pkg::IDX_W-1:0]    slot_index;
    logic [spa_pkg::GEN_BITS-1:0] generation;
    logic [spa_pkg::OFF_W-1:0]    slot_offset;
    logic [spa_pkg::CNT_W-1:0]    free_count;
    spa_pkg::t_status             status;

    modport source (output valid, slot_index, generation, slot_offset, free_count, status,
                    input ready);
    modport sink   (input valid, slot_index, generation, slot_offset, free_count, status,
                    output ready);
endinterface

interface spa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [spa_pkg::CFG_IDX_W-1:0]  index;
    logic [spa_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/slot_pool_allocator.sv @@
// One item at a time: input ready is high only in idle, so a new item is accepted
// only after the last result has been handed to the output register.
// A get reads the free stack and generation memory (S_GRD, S_GUPD); on an empty pool
// it returns ST_EMPTY without reading them. A return runs the restoring divider, one quotient bit per cycle;
// init runs the one-entry-per-cycle sweep of the stack and generation memories.
// Reset (i_rst_n low, synchronous) starts a fill pass; no item is accepted
// until it ends, configuration writes are taken throughout.
module slot_pool_allocator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spa_in_if.sink    i_in,
    spa_out_if.source o_out,
    spa_cfg_if.sink   i_cfg
);

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_GRD,
        S_GUPD,
        S_DIV,
        S_RFIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [spa_pkg::IDX_W-1:0]    slot_index;
        logic [spa_pkg::GEN_BITS-1:0] generation;
        logic [spa_pkg::OFF_W-1:0]    slot_offset;
        logic [spa_pkg::CNT_W-1:0]    free_count;
        spa_pkg::t_status             status;
    } t_res;

    localparam int PROD_W = spa_pkg::BYTES_W + spa_pkg::IDX_W;

    t_state                         r_state;
    logic [spa_pkg::SEQ_W-1:0]      r_cnt;
    logic [spa_pkg::CNT_W-1:0]      r_fill_n;
    logic                           r_fill_res;
    logic [spa_pkg::CNT_W-1:0]      r_depth;
    logic [spa_pkg::BYTES_W-1:0]    r_slot_bytes;
    logic [spa_pkg::CNT_W-1:0]      r_slots_in_use;
    logic [spa_pkg::IDX_W-1:0]      r_slot;
    logic [spa_pkg::OFF_W-1:0]      r_quo;
    logic [spa_pkg::BYTES_W-1:0]    r_rem;
    t_res                           r_res;
    t_res                           r_out;
    logic                           r_out_valid;
    logic [spa_pkg::IDX_W-1:0]      r_stk_rd;
    logic [spa_pkg::GEN_BITS-1:0]   r_gen_rd;

    logic [spa_pkg::IDX_W-1:0]      r_stk_mem [spa_pkg::MAX_SLOTS];
    logic [spa_pkg::GEN_BITS-1:0]   r_gen_mem [spa_pkg::MAX_SLOTS];

    logic                           in_acc;
    logic                           out_free;
    logic [spa_pkg::CNT_W-1:0]      eff_n;
    logic [spa_pkg::BYTES_W-1:0]    eff_bytes;
    logic [spa_pkg::BYTES_W:0]      rem_sh;
    logic [spa_pkg::BYTES_W+1:0]    diff;
    logic                           ge;
    logic [spa_pkg::GEN_BITS-1:0]   gen_inc;
    logic [PROD_W-1:0]              prod;
    logic [spa_pkg::CNT_W-1:0]      fill_pos;
    logic [spa_pkg::CNT_W-1:0]      fill_sub;
    logic [spa_pkg::IDX_W-1:0]      fill_val;
    logic                           fill_end;
    logic                           div_end;
    logic [spa_pkg::CNT_W-1:0]      depth_dec;
    logic                           ret_full;
    logic                           ret_range;
    logic                           ret_ok;
    logic                           stk_we;
    logic [spa_pkg::IDX_W-1:0]      stk_wa;
    logic [spa_pkg::IDX_W-1:0]      stk_wd;
    logic [spa_pkg::IDX_W-1:0]      stk_ra;
    logic                           gen_we;
    logic [spa_pkg::IDX_W-1:0]      gen_wa;
    logic [spa_pkg::GEN_BITS-1:0]   gen_wd;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;
    assign out_free    = !r_out_valid || o_out.ready;

    always_comb begin
        priority if (r_slots_in_use == '0) begin
            eff_n = spa_pkg::CNT_W'(1);
        end else if (r_slots_in_use > spa_pkg::CNT_W'(spa_pkg::MAX_SLOTS)) begin
            eff_n = spa_pkg::CNT_W'(spa_pkg::MAX_SLOTS);
        end else begin
            eff_n = r_slots_in_use;
        end
    end

    assign eff_bytes = (r_slot_bytes == '0) ? spa_pkg::BYTES_W'(1) : r_slot_bytes;

    assign rem_sh  = {r_rem, r_quo[spa_pkg::OFF_W-1]};
    assign diff    = {1'b0, rem_sh} - {2'b00, eff_bytes};
    assign ge      = !diff[spa_pkg::BYTES_W+1];
    assign div_end = (r_cnt == spa_pkg::SEQ_W'(spa_pkg::OFF_W - 1));

    assign gen_inc = r_gen_rd + spa_pkg::GEN_BITS'(1);
    assign prod    = PROD_W'(eff_bytes) * PROD_W'(r_slot);

    assign fill_pos = spa_pkg::CNT_W'(r_cnt[spa_pkg::IDX_W-1:0]);
    assign fill_sub = r_fill_n - spa_pkg::CNT_W'(1) - fill_pos;
    assign fill_val = (fill_pos < r_fill_n) ? fill_sub[spa_pkg::IDX_W-1:0] : '0;
    assign fill_end = (r_cnt[spa_pkg::IDX_W-1:0] == spa_pkg::IDX_W'(spa_pkg::MAX_SLOTS - 1));

    assign depth_dec = r_depth - spa_pkg::CNT_W'(1);
    assign ret_full  = (r_depth >= eff_n);
    assign ret_range = (r_quo >= spa_pkg::OFF_W'(eff_n));
    assign ret_ok    = !ret_full && !ret_range;

    assign stk_we = (r_state == S_FILL) || ((r_state == S_RFIN) && ret_ok);
    assign stk_wa = (r_state == S_FILL) ? r_cnt[spa_pkg::IDX_W-1:0]
                                        : r_depth[spa_pkg::IDX_W-1:0];
    assign stk_wd = (r_state == S_FILL) ? fill_val : r_quo[spa_pkg::IDX_W-1:0];
    assign stk_ra = depth_dec[spa_pkg::IDX_W-1:0];

    assign gen_we = (r_state == S_FILL) || (r_state == S_GUPD);
    assign gen_wa = (r_state == S_FILL) ? r_cnt[spa_pkg::IDX_W-1:0] : r_slot;
    assign gen_wd = (r_state == S_FILL) ? '0 : gen_inc;

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_wa] <= stk_wd;
        end
        r_stk_rd <= r_stk_mem[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (gen_we) begin
            r_gen_mem[gen_wa] <= gen_wd;
        end
        r_gen_rd <= r_gen_mem[r_stk_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_FILL;
            r_cnt          <= '0;
            r_fill_n       <= spa_pkg::CNT_W'(spa_pkg::MAX_SLOTS);
            r_fill_res     <= 1'b0;
            r_depth        <= '0;
            r_out_valid    <= 1'b0;
            r_slot_bytes   <= spa_pkg::SLOT_BYTES_RST;
            r_slots_in_use <= spa_pkg::SLOTS_IN_USE_RST;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    spa_pkg::REG_SLOT_BYTES: begin
                        r_slot_bytes <= i_cfg.data[spa_pkg::BYTES_W-1:0];
                    end
                    spa_pkg::REG_SLOTS_IN_USE: begin
                        r_slots_in_use <= i_cfg.data[spa_pkg::CNT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_FILL: begin
                    if (fill_end) begin
                        r_cnt   <= '0;
                        r_depth <= r_fill_n;
                        r_res   <= '{slot_index: '0, generation: '0, slot_offset: '0,
                                     free_count: r_fill_n, status: spa_pkg::ST_OK};
                        r_state <= r_fill_res ? S_DONE : S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + spa_pkg::SEQ_W'(1);
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_in.opcode)
                            spa_pkg::OP_GET: begin
                                if (r_depth == '0) begin
                                    r_res   <= '{slot_index: '0, generation: '0,
                                                 slot_offset: '0, free_count: r_depth,
                                                 status: spa_pkg::ST_EMPTY};
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_GRD;
                                end
                            end
                            spa_pkg::OP_RET: begin
                                r_quo   <= i_in.byte_offset;
                                r_rem   <= '0;
                                r_cnt   <= '0;
                                r_state <= S_DIV;
                            end
                            spa_pkg::OP_INIT: begin
                                r_fill_n   <= eff_n;
                                r_fill_res <= 1'b1;
                                r_cnt      <= '0;
                                r_state    <= S_FILL;
                            end
                            spa_pkg::OP_NOP: begin
                                r_res   <= '{slot_index: '0, generation: '0, slot_offset: '0,
                                             free_count: r_depth, status: spa_pkg::ST_OK};
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_GRD: begin
                    r_slot  <= r_stk_rd;
                    r_state <= S_GUPD;
                end
                S_GUPD: begin
                    r_res   <= '{slot_index: r_slot, generation: gen_inc,
                                 slot_offset: prod[spa_pkg::OFF_W-1:0],
                                 free_count: depth_dec, status: spa_pkg::ST_OK};
                    r_depth <= depth_dec;
                    r_state <= S_DONE;
                end
                S_DIV: begin
                    r_rem <= ge ? diff[spa_pkg::BYTES_W-1:0] : rem_sh[spa_pkg::BYTES_W-1:0];
                    r_quo <= {r_quo[spa_pkg::OFF_W-2:0], ge};
                    r_cnt <= r_cnt + spa_pkg::SEQ_W'(1);
                    if (div_end) begin
                        r_state <= S_RFIN;
                    end
                end
                S_RFIN: begin
                    priority if (ret_full) begin
                        r_res <= '{slot_index: r_quo[spa_pkg::IDX_W-1:0], generation: '0,
                                   slot_offset: '0, free_count: r_depth,
                                   status: spa_pkg::ST_FULL};
                    end else if (ret_range) begin
                        r_res <= '{slot_index: r_quo[spa_pkg::IDX_W-1:0], generation: '0,
                                   slot_offset: '0, free_count: r_depth,
                                   status: spa_pkg::ST_RANGE};
                    end else begin
                        r_res   <= '{slot_index: r_quo[spa_pkg::IDX_W-1:0], generation: '0,
                                     slot_offset: '0,
                                     free_count: r_depth + spa_pkg::CNT_W'(1),
                                     status: spa_pkg::ST_OK};
                        r_depth <= r_depth + spa_pkg::CNT_W'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.slot_index  = r_out.slot_index;
    assign o_out.generation  = r_out.generation;
    assign o_out.slot_offset = r_out.slot_offset;
    assign o_out.free_count  = r_out.free_count;
    assign o_out.status      = r_out.status;

`ifndef ASSERT_OFF
    a_accept_drops_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("input ready stayed high after an accepted item");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RFIN && ret_ok) |=> (r_depth == $past(r_depth) + spa_pkg::CNT_W'(1)))
        else $error("free count did not grow on a good return");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GUPD) |=> (r_depth == $past(r_depth) - spa_pkg::CNT_W'(1)))
        else $error("free count did not shrink on a get");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= spa_pkg::CNT_W'(spa_pkg::MAX_SLOTS))
        else $error("free count above pool capacity");
`endif

endmodule
